[src/kpa_pkg.sv]
// kpa_pkg: shared types, widths, register codes and helpers of kmeans_pixel_assign
// no dependencies

package kpa_pkg;

    localparam int MAX_CENTERS_DEF = 16;

    localparam int COMP_W  = 20;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int SLOT_W  = 4;
    localparam int OUT_W   = 8;
    localparam int SCALE_W = 16;
    localparam int INVC_W  = 24;
    localparam int NUMC_W  = 5;
    localparam int CFEAT_W = PIX_W + SCALE_W;
    localparam int PPROD_W = POS_W + SCALE_W;
    localparam int PFULL_W = PPROD_W + SCALE_W;
    localparam int FEAT_W  = PFULL_W - 16;
    localparam int SQ_W    = 2 * FEAT_W;
    localparam int DIST_W  = SQ_W + 3;
    localparam int RPROD_W = COMP_W + INVC_W;
    localparam int NUM_DIMS = 5;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [NUMC_W-1:0]  NUM_CENTERS_RST = NUMC_W'(1);
    localparam logic [SCALE_W-1:0] COL_WEIGHT_RST  = SCALE_W'(256);
    localparam logic [INVC_W-1:0]  INV_COLOR_RST   = INVC_W'(65536);
    localparam logic [SCALE_W-1:0] POS_WEIGHT_RST  = SCALE_W'(256);
    localparam logic [SCALE_W-1:0] INV_WIDTH_RST   = SCALE_W'(102);
    localparam logic [SCALE_W-1:0] INV_HEIGHT_RST  = SCALE_W'(137);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        REG_NUM_CENTERS,
        REG_COL_WEIGHT,
        REG_INV_COL_WEIGHT,
        REG_POS_WEIGHT,
        REG_INV_WIDTH,
        REG_INV_HEIGHT
    } kpa_reg_t;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] center_slot;
        logic [COMP_W-1:0] center_blue;
        logic [COMP_W-1:0] center_green;
        logic [COMP_W-1:0] center_red;
        logic [COMP_W-1:0] center_xpos;
        logic [COMP_W-1:0] center_ypos;
        logic [PIX_W-1:0]  pixel_blue;
        logic [PIX_W-1:0]  pixel_green;
        logic [PIX_W-1:0]  pixel_red;
        logic [POS_W-1:0]  pixel_column;
        logic [POS_W-1:0]  pixel_row;
    } kpa_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] best_center;
        logic [OUT_W-1:0]  seg_blue;
        logic [OUT_W-1:0]  seg_green;
        logic [OUT_W-1:0]  seg_red;
    } kpa_result_t;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] xpos;
        logic [COMP_W-1:0] ypos;
    } kpa_center_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        kpa_center_t       center;
    } kpa_load_t;

    typedef struct packed {
        logic [FEAT_W-1:0] blue;
        logic [FEAT_W-1:0] green;
        logic [FEAT_W-1:0] red;
        logic [FEAT_W-1:0] xpos;
        logic [FEAT_W-1:0] ypos;
    } kpa_feat_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sqdist;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } kpa_token_t;

    function automatic logic [FEAT_W-1:0] abs_diff(logic [FEAT_W-1:0] f, logic [COMP_W-1:0] c);
        logic [FEAT_W-1:0] ce;
        ce = FEAT_W'(c);
        return (f >= ce) ? (f - ce) : (ce - f);
    endfunction

    // round half to even, saturate to 255
    function automatic logic [OUT_W-1:0] round_sat(logic [RPROD_W-1:0] v);
        logic [COMP_W-1:0] q;
        logic [23:0]       r;
        logic              up;
        logic [COMP_W:0]   q1;
        q  = v[RPROD_W-1:24];
        r  = v[23:0];
        up = (r > 24'h800000) || ((r == 24'h800000) && q[0]);
        q1 = (COMP_W+1)'(q) + (COMP_W+1)'(up);
        return (q1 > (COMP_W+1)'(255)) ? OUT_W'(255) : q1[OUT_W-1:0];
    endfunction

endpackage

[src/kpa_feature.sv]
// kpa_feature: two-stage feature builder, scaled color and normalized position
// depends on kpa_pkg

module kpa_feature
(
    input  logic                          clk,
    input  kpa_pkg::kpa_item_t            pix,
    input  logic [kpa_pkg::SCALE_W-1:0]   col_weight,
    input  logic [kpa_pkg::SCALE_W-1:0]   pos_weight,
    input  logic [kpa_pkg::SCALE_W-1:0]   inv_width,
    input  logic [kpa_pkg::SCALE_W-1:0]   inv_height,
    output kpa_pkg::kpa_feat_t            feat
);

    logic [kpa_pkg::CFEAT_W-1:0] cb_reg, cg_reg, cr_reg;
    logic [kpa_pkg::PPROD_W-1:0] xp_reg, yp_reg;
    kpa_pkg::kpa_feat_t          feat_reg;
    logic [kpa_pkg::PFULL_W-1:0] xfull, yfull;

    always_ff @(posedge clk)
    begin
        cb_reg <= kpa_pkg::CFEAT_W'(pix.pixel_blue)  * kpa_pkg::CFEAT_W'(col_weight);
        cg_reg <= kpa_pkg::CFEAT_W'(pix.pixel_green) * kpa_pkg::CFEAT_W'(col_weight);
        cr_reg <= kpa_pkg::CFEAT_W'(pix.pixel_red)   * kpa_pkg::CFEAT_W'(col_weight);
        xp_reg <= kpa_pkg::PPROD_W'(pix.pixel_column) * kpa_pkg::PPROD_W'(inv_width);
        yp_reg <= kpa_pkg::PPROD_W'(pix.pixel_row)    * kpa_pkg::PPROD_W'(inv_height);
    end

    // rounding half up from 24 to 8 fraction bits
    always_comb
    begin
        xfull = kpa_pkg::PFULL_W'(xp_reg) * kpa_pkg::PFULL_W'(pos_weight)
              + kpa_pkg::PFULL_W'(32'h8000);
        yfull = kpa_pkg::PFULL_W'(yp_reg) * kpa_pkg::PFULL_W'(pos_weight)
              + kpa_pkg::PFULL_W'(32'h8000);
    end

    always_ff @(posedge clk)
    begin
        feat_reg.blue  <= kpa_pkg::FEAT_W'(cb_reg);
        feat_reg.green <= kpa_pkg::FEAT_W'(cg_reg);
        feat_reg.red   <= kpa_pkg::FEAT_W'(cr_reg);
        feat_reg.xpos  <= xfull[kpa_pkg::PFULL_W-1:16];
        feat_reg.ypos  <= yfull[kpa_pkg::PFULL_W-1:16];
    end

    assign feat = feat_reg;

endmodule

[src/kpa_cell.sv]
// kpa_cell: one center of the search chain, distance pipeline and best-so-far compare
// depends on kpa_pkg

module kpa_cell
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  kpa_pkg::kpa_load_t      load,
    input  kpa_pkg::kpa_feat_t      feat,
    input  logic                    active,
    input  kpa_pkg::kpa_token_t     tok_in,
    input  logic [IDX_W-1:0]        idx_in,
    output kpa_pkg::kpa_token_t     tok_out,
    output logic [IDX_W-1:0]        idx_out
);

    kpa_pkg::kpa_center_t        center_reg;
    logic [kpa_pkg::FEAT_W-1:0]  diff_reg [kpa_pkg::NUM_DIMS];
    logic [kpa_pkg::SQ_W-1:0]    sq_reg   [kpa_pkg::NUM_DIMS];
    logic [kpa_pkg::DIST_W-1:0]  sqdist_reg;
    kpa_pkg::kpa_token_t         tok_reg;
    logic [IDX_W-1:0]            idx_reg;

    logic [kpa_pkg::FEAT_W-1:0]  feat_arr [kpa_pkg::NUM_DIMS];
    logic [kpa_pkg::COMP_W-1:0]  comp_arr [kpa_pkg::NUM_DIMS];
    logic [kpa_pkg::DIST_W-1:0]  sqdist_next;
    logic                        take;

    always_comb
    begin
        feat_arr[0] = feat.blue;
        feat_arr[1] = feat.green;
        feat_arr[2] = feat.red;
        feat_arr[3] = feat.xpos;
        feat_arr[4] = feat.ypos;
        comp_arr[0] = center_reg.blue;
        comp_arr[1] = center_reg.green;
        comp_arr[2] = center_reg.red;
        comp_arr[3] = center_reg.xpos;
        comp_arr[4] = center_reg.ypos;
    end

    always_ff @(posedge clk)
    begin
        if (load.en && (32'(load.slot) == INDEX))
        begin
            center_reg <= load.center;
        end
    end

    always_comb
    begin
        sqdist_next = '0;
        for (int k = 0; k < kpa_pkg::NUM_DIMS; k++)
        begin
            sqdist_next = sqdist_next + kpa_pkg::DIST_W'(sq_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < kpa_pkg::NUM_DIMS; k++)
        begin
            diff_reg[k] <= kpa_pkg::abs_diff(feat_arr[k], comp_arr[k]);
            sq_reg[k]   <= kpa_pkg::SQ_W'(diff_reg[k]) * kpa_pkg::SQ_W'(diff_reg[k]);
        end
        sqdist_reg <= sqdist_next;
    end

    // first cell always takes, later cells take only when active and on strictly smaller distance
    assign take = (INDEX == 0) || (active && (sqdist_reg < tok_in.sqdist));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            tok_reg.valid <= tok_in.valid;
            if (take)
            begin
                tok_reg.sqdist <= sqdist_reg;
                tok_reg.blue   <= center_reg.blue;
                tok_reg.green  <= center_reg.green;
                tok_reg.red    <= center_reg.red;
                idx_reg        <= IDX_W'(INDEX);
            end
            else
            begin
                tok_reg.sqdist <= tok_in.sqdist;
                tok_reg.blue   <= tok_in.blue;
                tok_reg.green  <= tok_in.green;
                tok_reg.red    <= tok_in.red;
                idx_reg        <= idx_in;
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

[src/kmeans_pixel_assign.sv]
// kmeans_pixel_assign: top level, config registers, chain of center cells, color rescale
// depends on kpa_pkg, kpa_feature, kpa_cell

// Usage
// item channel (item_valid/item_stall/item): op 0 loads a center into one cell of
// the chain and yields no result; op 1 classifies a pixel.
// result channel (result_valid/result_stall/result): one transaction per pixel,
// nearest center index and that center's color rescaled to 8 bits.
// a pixel passes through the input register, the feature build and the cell distance
// pipelines, then the best-so-far token walks the chain cell by cell, then the
// rescale and output registers.
// one pixel is in flight at a time, and the next is taken once the last result
// enters the output register; loads are taken every cycle while no pixel is in flight.
// a finished result waits in the output register while the next pixel runs;
// if the receiver still stalls when that pixel is done, it waits in the rescale
// stage and item_stall stays high until it moves on.
// reset clears control state and config registers to their defaults; center
// contents are undefined until loaded. APB writes only while idle.

module kmeans_pixel_assign
#(
    parameter int MAX_CENTERS = kpa_pkg::MAX_CENTERS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  kpa_pkg::kpa_item_t          item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output kpa_pkg::kpa_result_t        result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kpa_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpa_pkg::DATA_W-1:0]  pwdata,
    output logic [kpa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int IDX_W        = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int LAUNCH_DEPTH = 6;

    logic [kpa_pkg::NUMC_W-1:0]  num_centers_reg;
    logic [kpa_pkg::SCALE_W-1:0] col_weight_reg;
    logic [kpa_pkg::INVC_W-1:0]  inv_color_reg;
    logic [kpa_pkg::SCALE_W-1:0] pos_weight_reg;
    logic [kpa_pkg::SCALE_W-1:0] inv_width_reg;
    logic [kpa_pkg::SCALE_W-1:0] inv_height_reg;

    logic                        busy_reg;
    kpa_pkg::kpa_item_t          pix_reg;
    logic [LAUNCH_DEPTH-1:0]     launch_reg;

    logic                        prod_valid_reg;
    logic [kpa_pkg::RPROD_W-1:0] prod_b_reg, prod_g_reg, prod_r_reg;
    logic [IDX_W-1:0]            prod_idx_reg;

    logic                        out_valid_reg;
    kpa_pkg::kpa_result_t        result_reg;

    logic                        accept;
    logic                        pixel_accept;
    logic                        cfg_write;
    logic                        prod_move;
    kpa_pkg::kpa_reg_t           reg_sel;
    kpa_pkg::kpa_load_t          load;
    kpa_pkg::kpa_feat_t          feat;
    logic [MAX_CENTERS-1:0]      active;
    kpa_pkg::kpa_token_t         tok_head;
    kpa_pkg::kpa_token_t         tok [MAX_CENTERS+1];
    logic [IDX_W-1:0]            idx [MAX_CENTERS+1];
    logic [IDX_W+3:0]            idx_ext;

    assign accept       = item_valid && !busy_reg;
    assign pixel_accept = accept && (item.op == kpa_pkg::OP_PIXEL);
    assign item_stall   = busy_reg;

    // apb
    assign pready    = 1'b1;
    assign reg_sel   = kpa_pkg::kpa_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            kpa_pkg::REG_NUM_CENTERS:    prdata = kpa_pkg::DATA_W'(num_centers_reg);
            kpa_pkg::REG_COL_WEIGHT:     prdata = kpa_pkg::DATA_W'(col_weight_reg);
            kpa_pkg::REG_INV_COL_WEIGHT: prdata = kpa_pkg::DATA_W'(inv_color_reg);
            kpa_pkg::REG_POS_WEIGHT:     prdata = kpa_pkg::DATA_W'(pos_weight_reg);
            kpa_pkg::REG_INV_WIDTH:      prdata = kpa_pkg::DATA_W'(inv_width_reg);
            kpa_pkg::REG_INV_HEIGHT:     prdata = kpa_pkg::DATA_W'(inv_height_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centers_reg <= kpa_pkg::NUM_CENTERS_RST;
            col_weight_reg  <= kpa_pkg::COL_WEIGHT_RST;
            inv_color_reg   <= kpa_pkg::INV_COLOR_RST;
            pos_weight_reg  <= kpa_pkg::POS_WEIGHT_RST;
            inv_width_reg   <= kpa_pkg::INV_WIDTH_RST;
            inv_height_reg  <= kpa_pkg::INV_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                kpa_pkg::REG_NUM_CENTERS:
                    num_centers_reg <= pwdata[kpa_pkg::NUMC_W-1:0];
                kpa_pkg::REG_COL_WEIGHT:
                    col_weight_reg <= pwdata[kpa_pkg::SCALE_W-1:0];
                kpa_pkg::REG_INV_COL_WEIGHT:
                    inv_color_reg <= pwdata[kpa_pkg::INVC_W-1:0];
                kpa_pkg::REG_POS_WEIGHT:
                    pos_weight_reg <= pwdata[kpa_pkg::SCALE_W-1:0];
                kpa_pkg::REG_INV_WIDTH:
                    inv_width_reg <= pwdata[kpa_pkg::SCALE_W-1:0];
                kpa_pkg::REG_INV_HEIGHT:
                    inv_height_reg <= pwdata[kpa_pkg::SCALE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // control
    assign prod_move = prod_valid_reg && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            launch_reg     <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pixel_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (prod_move)
            begin
                busy_reg <= 1'b0;
            end
            launch_reg <= {launch_reg[LAUNCH_DEPTH-2:0], pixel_accept};
            if (tok[MAX_CENTERS].valid)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (prod_move)
            begin
                prod_valid_reg <= 1'b0;
            end
            if (prod_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            pix_reg <= item;
        end
    end

    always_comb
    begin
        load.en            = accept && (item.op == kpa_pkg::OP_LOAD);
        load.slot          = item.center_slot;
        load.center.blue   = item.center_blue;
        load.center.green  = item.center_green;
        load.center.red    = item.center_red;
        load.center.xpos   = item.center_xpos;
        load.center.ypos   = item.center_ypos;
    end

    kpa_feature u_feature
    (
        .clk        (clk),
        .pix        (pix_reg),
        .col_weight (col_weight_reg),
        .pos_weight (pos_weight_reg),
        .inv_width  (inv_width_reg),
        .inv_height (inv_height_reg),
        .feat       (feat)
    );

    // search chain
    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = launch_reg[LAUNCH_DEPTH-1];
    end

    assign tok[0] = tok_head;
    assign idx[0] = '0;

    for (genvar i = 0; i < MAX_CENTERS; i++)
    begin : g_cell
        assign active[i] = (i == 0) || (32'(num_centers_reg) > i);

        kpa_cell
        #(
            .INDEX (i),
            .IDX_W (IDX_W)
        )
        u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .feat    (feat),
            .active  (active[i]),
            .tok_in  (tok[i]),
            .idx_in  (idx[i]),
            .tok_out (tok[i+1]),
            .idx_out (idx[i+1])
        );
    end

    // rescale and output
    always_ff @(posedge clk)
    begin
        if (tok[MAX_CENTERS].valid)
        begin
            prod_b_reg   <= kpa_pkg::RPROD_W'(tok[MAX_CENTERS].blue)
                          * kpa_pkg::RPROD_W'(inv_color_reg);
            prod_g_reg   <= kpa_pkg::RPROD_W'(tok[MAX_CENTERS].green)
                          * kpa_pkg::RPROD_W'(inv_color_reg);
            prod_r_reg   <= kpa_pkg::RPROD_W'(tok[MAX_CENTERS].red)
                          * kpa_pkg::RPROD_W'(inv_color_reg);
            prod_idx_reg <= idx[MAX_CENTERS];
        end
    end

    assign idx_ext = (IDX_W+4)'(prod_idx_reg);

    always_ff @(posedge clk)
    begin
        if (prod_move)
        begin
            result_reg.best_center <= idx_ext[3:0];
            result_reg.seg_blue    <= kpa_pkg::round_sat(prod_b_reg);
            result_reg.seg_green   <= kpa_pkg::round_sat(prod_g_reg);
            result_reg.seg_red     <= kpa_pkg::round_sat(prod_r_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

[src/kpa_checker.sv]
// kpa_checker: port-level assertions for kmeans_pixel_assign, bound to the top level
// depends on kpa_pkg and kmeans_pixel_assign

module kpa_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_stall,
    input kpa_pkg::kpa_item_t          item,
    input logic                        result_valid,
    input logic                        result_stall,
    input kpa_pkg::kpa_result_t        result
);

    // a pixel transaction occupies the chain
    a_pixel_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.op == kpa_pkg::OP_PIXEL)) |=> item_stall)
        else $error("pixel accepted without stalling the item channel");

    // a load transaction never blocks the next one
    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.op == kpa_pkg::OP_LOAD)) |=> !item_stall)
        else $error("load transaction stalled the item channel");

    // a new result only comes from a pixel in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared with no pixel in flight");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind kmeans_pixel_assign kpa_checker u_kpa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[bench/kmeans_pixel_assign_tb.sv]
// kmeans_pixel_assign_tb: self-checking bench for the nearest-center pixel classifier
// drives center loads and pixels on the item channel and config over apb, checks results
// depends on kpa_pkg and kmeans_pixel_assign

`timescale 1ns / 1ps

module kmeans_pixel_assign_tb;

    localparam int CENTERS      = kpa_pkg::MAX_CENTERS_DEF;
    localparam int DRAIN_CYCLES = CENTERS + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 60;
    localparam int HOLD_PHASE   = 5;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_REGS     = 6;

    localparam logic [kpa_pkg::COMP_W-1:0] COMP_MAX = {kpa_pkg::COMP_W{1'b1}};

    localparam kpa_pkg::kpa_result_t SEG_SLOT0 =
        '{best_center: 4'd0, seg_blue: 8'd0, seg_green: 8'd255, seg_red: 8'd128};
    localparam kpa_pkg::kpa_result_t SEG_SLOT1 =
        '{best_center: 4'd1, seg_blue: 8'd0, seg_green: 8'd0, seg_red: 8'd0};

    typedef struct {
        bit                   cfg;
        kpa_pkg::kpa_reg_t    reg_sel;
        logic [31:0]          value;
        kpa_pkg::kpa_item_t   it;
        bit                   typed;
        kpa_pkg::kpa_result_t res;
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    kpa_pkg::kpa_item_t            item;
    logic                          result_valid;
    logic                          result_stall;
    kpa_pkg::kpa_result_t          result;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [kpa_pkg::ADDR_W-1:0]    paddr;
    logic [kpa_pkg::DATA_W-1:0]    pwdata;
    logic [kpa_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    kpa_pkg::kpa_center_t          center_mem [CENTERS];
    logic [kpa_pkg::NUMC_W-1:0]    cfg_num_centers;
    logic [kpa_pkg::SCALE_W-1:0]   cfg_col_weight;
    logic [kpa_pkg::INVC_W-1:0]    cfg_inv_color;
    logic [kpa_pkg::SCALE_W-1:0]   cfg_pos_weight;
    logic [kpa_pkg::SCALE_W-1:0]   cfg_inv_width;
    logic [kpa_pkg::SCALE_W-1:0]   cfg_inv_height;

    kpa_pkg::kpa_result_t          seg_expected [$];
    dir_row_t                      dir_rows [$];
    int                            errors;
    int                            cycle_count;
    bit                            idle_on;
    bit                            hold_req;

    kmeans_pixel_assign #(.MAX_CENTERS(CENTERS)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] pos_to_feature(logic [kpa_pkg::POS_W-1:0] pos,
                                                   logic [kpa_pkg::SCALE_W-1:0] inv_size);
        logic [63:0] p;
        p = 64'(pos) * 64'(inv_size) * 64'(cfg_pos_weight);
        return (p + 64'h8000) >> 16;
    endfunction

    // round half to even, saturate at 255
    function automatic logic [kpa_pkg::OUT_W-1:0] color_back(logic [kpa_pkg::COMP_W-1:0] comp);
        logic [63:0] v;
        logic [63:0] q;
        logic [23:0] r;
        v = 64'(comp) * 64'(cfg_inv_color);
        q = v >> 24;
        r = v[23:0];
        if (r > 24'h800000 || (r == 24'h800000 && q[0]))
            q = q + 1;
        return (q > 64'd255) ? kpa_pkg::OUT_W'(255) : q[kpa_pkg::OUT_W-1:0];
    endfunction

    function automatic kpa_pkg::kpa_result_t seg_predict(kpa_pkg::kpa_item_t it);
        logic [63:0]          feat [kpa_pkg::NUM_DIMS];
        logic [63:0]          comp [kpa_pkg::NUM_DIMS];
        logic [63:0]          cand_dist;
        logic [63:0]          best_dist;
        logic [63:0]          diff;
        int                   count;
        int                   best;
        kpa_pkg::kpa_result_t res;
        feat[0] = 64'(it.pixel_blue) * 64'(cfg_col_weight);
        feat[1] = 64'(it.pixel_green) * 64'(cfg_col_weight);
        feat[2] = 64'(it.pixel_red) * 64'(cfg_col_weight);
        feat[3] = pos_to_feature(it.pixel_column, cfg_inv_width);
        feat[4] = pos_to_feature(it.pixel_row, cfg_inv_height);
        count = int'(cfg_num_centers);
        if (count == 0)
            count = 1;
        if (count > CENTERS)
            count = CENTERS;
        best = 0;
        best_dist = '0;
        for (int i = 0; i < count; i++)
        begin
            comp[0] = 64'(center_mem[i].blue);
            comp[1] = 64'(center_mem[i].green);
            comp[2] = 64'(center_mem[i].red);
            comp[3] = 64'(center_mem[i].xpos);
            comp[4] = 64'(center_mem[i].ypos);
            cand_dist = '0;
            for (int d = 0; d < kpa_pkg::NUM_DIMS; d++)
            begin
                diff = (feat[d] >= comp[d]) ? feat[d] - comp[d] : comp[d] - feat[d];
                cand_dist = cand_dist + diff * diff;
            end
            if (i == 0 || cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best = i;
            end
        end
        res.best_center = kpa_pkg::SLOT_W'(best);
        res.seg_blue    = color_back(center_mem[best].blue);
        res.seg_green   = color_back(center_mem[best].green);
        res.seg_red     = color_back(center_mem[best].red);
        return res;
    endfunction

    function automatic dir_row_t load_row(int slot, logic [kpa_pkg::COMP_W-1:0] b,
                                          logic [kpa_pkg::COMP_W-1:0] g,
                                          logic [kpa_pkg::COMP_W-1:0] r,
                                          logic [kpa_pkg::COMP_W-1:0] x,
                                          logic [kpa_pkg::COMP_W-1:0] y);
        dir_row_t row;
        row.cfg = 1'b0;
        row.reg_sel = kpa_pkg::REG_NUM_CENTERS;
        row.value = '0;
        row.it = '0;
        row.it.op = kpa_pkg::OP_LOAD;
        row.it.center_slot = kpa_pkg::SLOT_W'(slot);
        row.it.center_blue = b;
        row.it.center_green = g;
        row.it.center_red = r;
        row.it.center_xpos = x;
        row.it.center_ypos = y;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic dir_row_t pixel_row(int b, int g, int r, int col, int rw,
                                           bit typed, kpa_pkg::kpa_result_t res);
        dir_row_t row;
        row.cfg = 1'b0;
        row.reg_sel = kpa_pkg::REG_NUM_CENTERS;
        row.value = '0;
        row.it = '0;
        row.it.op = kpa_pkg::OP_PIXEL;
        row.it.pixel_blue = kpa_pkg::PIX_W'(b);
        row.it.pixel_green = kpa_pkg::PIX_W'(g);
        row.it.pixel_red = kpa_pkg::PIX_W'(r);
        row.it.pixel_column = kpa_pkg::POS_W'(col);
        row.it.pixel_row = kpa_pkg::POS_W'(rw);
        row.typed = typed;
        row.res = res;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(kpa_pkg::kpa_reg_t sel, logic [31:0] value);
        dir_row_t row;
        row.cfg = 1'b1;
        row.reg_sel = sel;
        row.value = value;
        row.it = '0;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    task automatic cfg_write(input kpa_pkg::kpa_reg_t sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kpa_pkg::ADDR_W'(4 * int'(sel));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (sel)
            kpa_pkg::REG_NUM_CENTERS:    cfg_num_centers = value[kpa_pkg::NUMC_W-1:0];
            kpa_pkg::REG_COL_WEIGHT:     cfg_col_weight  = value[kpa_pkg::SCALE_W-1:0];
            kpa_pkg::REG_INV_COL_WEIGHT: cfg_inv_color   = value[kpa_pkg::INVC_W-1:0];
            kpa_pkg::REG_POS_WEIGHT:     cfg_pos_weight  = value[kpa_pkg::SCALE_W-1:0];
            kpa_pkg::REG_INV_WIDTH:      cfg_inv_width   = value[kpa_pkg::SCALE_W-1:0];
            kpa_pkg::REG_INV_HEIGHT:     cfg_inv_height  = value[kpa_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // block goes idle before config writes
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (seg_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input kpa_pkg::kpa_item_t it, input bit typed,
                             input kpa_pkg::kpa_result_t res);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (it.op == kpa_pkg::OP_LOAD)
            center_mem[it.center_slot] = '{blue: it.center_blue, green: it.center_green,
                                           red: it.center_red, xpos: it.center_xpos,
                                           ypos: it.center_ypos};
        else
            seg_expected.push_back(typed ? res : seg_predict(it));
    endtask

    // result side: checks each transaction and drives stall
    initial
    begin
        kpa_pkg::kpa_result_t exp_res;
        int                   burst_left;
        int                   hold_left;
        bit                   stall_next;
        burst_left = 0;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (seg_expected.size() == 0)
                begin
                    $display("%0t unexpected result transaction, got %p", $time, result);
                    errors++;
                end
                else
                begin
                    exp_res = seg_expected.pop_front();
                    if (result.best_center !== exp_res.best_center)
                    begin
                        $display("%0t best_center expected %0d got %0d", $time,
                                 exp_res.best_center, result.best_center);
                        errors++;
                    end
                    if (result.seg_blue !== exp_res.seg_blue)
                    begin
                        $display("%0t seg_blue expected %0d got %0d", $time,
                                 exp_res.seg_blue, result.seg_blue);
                        errors++;
                    end
                    if (result.seg_green !== exp_res.seg_green)
                    begin
                        $display("%0t seg_green expected %0d got %0d", $time,
                                 exp_res.seg_green, result.seg_green);
                        errors++;
                    end
                    if (result.seg_red !== exp_res.seg_red)
                    begin
                        $display("%0t seg_red expected %0d got %0d", $time,
                                 exp_res.seg_red, result.seg_red);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                stall_next = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 14) - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            result_stall <= stall_next;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("kmeans_pixel_assign_tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [31:0]        phase_cfg [NUM_REGS];
        kpa_pkg::kpa_item_t it;
        errors = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cfg_num_centers = kpa_pkg::NUM_CENTERS_RST;
        cfg_col_weight  = kpa_pkg::COL_WEIGHT_RST;
        cfg_inv_color   = kpa_pkg::INV_COLOR_RST;
        cfg_pos_weight  = kpa_pkg::POS_WEIGHT_RST;
        cfg_inv_width   = kpa_pkg::INV_WIDTH_RST;
        cfg_inv_height  = kpa_pkg::INV_HEIGHT_RST;
        for (int i = 0; i < CENTERS; i++)
            center_mem[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config searches center 0 only
        dir_rows.push_back(load_row(0, '0, COMP_MAX, 20'h08080, '0, '0));
        dir_rows.push_back(pixel_row(0, 0, 0, 0, 0, 1'b1, SEG_SLOT0));
        dir_rows.push_back(pixel_row(255, 255, 255, 4095, 4095, 1'b1, SEG_SLOT0));
        dir_rows.push_back(pixel_row(0, 255, 0, 4095, 0, 1'b1, SEG_SLOT0));
        dir_rows.push_back(load_row(1, '0, '0, '0, '0, '0));
        dir_rows.push_back(load_row(2, '0, '0, '0, '0, '0));
        for (int s = 3; s < CENTERS - 1; s++)
            dir_rows.push_back(load_row(s, kpa_pkg::COMP_W'(s * 'h1100),
                                        kpa_pkg::COMP_W'((15 - s) * 'h1100),
                                        kpa_pkg::COMP_W'(s * 'h880),
                                        kpa_pkg::COMP_W'(s * 'h40),
                                        kpa_pkg::COMP_W'((15 - s) * 'h40)));
        dir_rows.push_back(load_row(CENTERS - 1, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                                    COMP_MAX));
        // zero count still searches center 0
        dir_rows.push_back(cfg_row(kpa_pkg::REG_NUM_CENTERS, 32'd0));
        dir_rows.push_back(pixel_row(128, 128, 128, 100, 100, 1'b1, SEG_SLOT0));
        // count above the store size is clamped
        dir_rows.push_back(cfg_row(kpa_pkg::REG_NUM_CENTERS, 32'd31));
        dir_rows.push_back(pixel_row(0, 0, 0, 0, 0, 1'b0, '0));
        dir_rows.push_back(pixel_row(255, 255, 255, 4095, 4095, 1'b0, '0));
        dir_rows.push_back(pixel_row(40, 200, 90, 2000, 1000, 1'b0, '0));
        // centers 1 and 2 tie, lower index wins
        dir_rows.push_back(cfg_row(kpa_pkg::REG_NUM_CENTERS, 32'd3));
        dir_rows.push_back(pixel_row(0, 0, 0, 0, 0, 1'b1, SEG_SLOT1));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
            begin
                wait_drained();
                cfg_write(dir_rows[i].reg_sel, dir_rows[i].value);
            end
            else
                send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:          phase_cfg = '{16, 256, 65536, 256, 102, 137};
                1:          phase_cfg = '{0, 256, 65536, 256, 102, 137};
                2:          phase_cfg = '{31, 65535, 24'hFFFFFF, 65535, 65535, 65535};
                3:          phase_cfg = '{16, 0, 0, 0, 0, 0};
                PHASES - 1: phase_cfg = '{16, 256, 65536, 256, 102, 137};
                default:
                    phase_cfg = '{$urandom_range(0, 31), $urandom_range(0, 65535),
                                  $urandom_range(4096, 262143), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535)};
            endcase
            if (p == PHASES - 1)
                idle_on = 1'b0;
            wait_drained();
            for (int k = 0; k < NUM_REGS; k++)
                cfg_write(kpa_pkg::kpa_reg_t'(k), phase_cfg[k]);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it.op           = ($urandom_range(0, 3) == 0) ? kpa_pkg::OP_LOAD
                                                              : kpa_pkg::OP_PIXEL;
                it.center_slot  = kpa_pkg::SLOT_W'($urandom);
                it.center_blue  = kpa_pkg::COMP_W'($urandom);
                it.center_green = kpa_pkg::COMP_W'($urandom);
                it.center_red   = kpa_pkg::COMP_W'($urandom);
                it.center_xpos  = kpa_pkg::COMP_W'($urandom);
                it.center_ypos  = kpa_pkg::COMP_W'($urandom);
                it.pixel_blue   = kpa_pkg::PIX_W'($urandom);
                it.pixel_green  = kpa_pkg::PIX_W'($urandom);
                it.pixel_red    = kpa_pkg::PIX_W'($urandom);
                it.pixel_column = kpa_pkg::POS_W'($urandom);
                it.pixel_row    = kpa_pkg::POS_W'($urandom);
                // most centers land where pixel features fall
                if (it.op == kpa_pkg::OP_LOAD && $urandom_range(0, 3) != 0)
                begin
                    it.center_blue  = kpa_pkg::COMP_W'(64'($urandom_range(0, 255)) *
                                      64'(cfg_col_weight) + $urandom_range(0, 511));
                    it.center_green = kpa_pkg::COMP_W'(64'($urandom_range(0, 255)) *
                                      64'(cfg_col_weight) + $urandom_range(0, 511));
                    it.center_red   = kpa_pkg::COMP_W'(64'($urandom_range(0, 255)) *
                                      64'(cfg_col_weight) + $urandom_range(0, 511));
                    it.center_xpos  = kpa_pkg::COMP_W'(
                                      pos_to_feature(kpa_pkg::POS_W'($urandom), cfg_inv_width)
                                      + $urandom_range(0, 63));
                    it.center_ypos  = kpa_pkg::COMP_W'(
                                      pos_to_feature(kpa_pkg::POS_W'($urandom), cfg_inv_height)
                                      + $urandom_range(0, 63));
                end
                send_item(it, 1'b0, '0);
            end
        end

        item_valid <= 1'b0;
        while (seg_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("kmeans_pixel_assign_tb OK");
        else
            $display("kmeans_pixel_assign_tb NOT OK");
        $finish;
    end

endmodule
